// ===== hw/rtl/hst_pkg.sv =====
// Package: shared widths, codes and types of the hot segment tracker.
package hst_pkg;

   localparam int ADDR_W      = 40;
   localparam int SEG_W       = 29;
   localparam int COUNT_W     = 8;
   localparam int STATUS_W    = 3;
   localparam int CAP_W       = 41;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 41;

   localparam int DEF_ENTRIES       = 64;
   localparam int DEF_SEGMENT_SHIFT = 11;
   localparam int DEF_COUNT_CEILING = 254;

   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IGNORE_WRITES = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IGNORE_STORES = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLEAR_ON_DUMP = 2'd3;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(1) << ADDR_W;

   localparam logic [STATUS_W-1:0] STAT_INCREMENTED = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_SATURATED   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_INSERTED    = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_DECREMENTED = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FILTERED    = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_OUT_OF_RANGE = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_DUMP        = 3'd6;

   localparam logic KIND_ACCESS = 1'b0;
   localparam logic KIND_DUMP   = 1'b1;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INC,
      OP_INSERT,
      OP_DEC,
      OP_SWAP,
      OP_ROTATE,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      logic               live;
      logic [SEG_W-1:0]   segment;
      logic [COUNT_W-1:0] count;
   } entry_type;

   localparam entry_type DEAD_ENTRY = '0;

   typedef struct packed {
      cell_op_type      op;
      logic [SEG_W-1:0] key;
      logic             phase;
   } cell_cmd_type;

   typedef struct packed {
      logic first;
      logic last;
      logic odd;
   } cell_pos_type;

   typedef struct packed {
      logic hit;
      logic sat;
      logic above;
   } cell_flags_type;

endpackage

// ===== hw/rtl/hst_if.sv =====
// Interfaces: request and response channels of the hot segment tracker.
interface hst_req_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [hst_pkg::ADDR_W-1:0] address;
   logic                       is_write;
   logic                       is_store_or_writeback;

   modport source (output valid, kind, address, is_write, is_store_or_writeback,
                   input ready);
   modport sink   (input valid, kind, address, is_write, is_store_or_writeback,
                   output ready);
endinterface

interface hst_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hst_pkg::STATUS_W-1:0] status;
   logic                         entry_valid;
   logic [hst_pkg::SEG_W-1:0]    segment;
   logic [hst_pkg::COUNT_W-1:0]  count;
   logic                         last;

   modport source (output valid, status, entry_valid, segment, count, last,
                   input ready);
   modport sink   (input valid, status, entry_valid, segment, count, last,
                   output ready);
endinterface

// ===== hw/rtl/hst_cell.sv =====
// Cell: one entry of the sorted counter chain with its local update rules.
module hst_cell #(
   parameter int COUNT_CEILING = hst_pkg::DEF_COUNT_CEILING
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hst_pkg::cell_cmd_type   cmd,
   input  hst_pkg::cell_pos_type   pos,
   input  hst_pkg::entry_type      left_entry,
   input  hst_pkg::entry_type      right_entry,
   input  logic                    left_above,
   output hst_pkg::entry_type      entry,
   output hst_pkg::cell_flags_type flags
);
   import hst_pkg::*;

   localparam logic [COUNT_W-1:0] CEIL = COUNT_W'(COUNT_CEILING);

   logic               live_ff, live_in;
   logic [SEG_W-1:0]   segment_ff, segment_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] dec_count;
   logic               pair_left;
   logic               pair_right;
   entry_type          next_entry;

   assign entry = '{live: live_ff, segment: segment_ff, count: count_ff};

   assign flags.hit   = live_ff && (segment_ff == cmd.key);
   assign flags.sat   = flags.hit && (count_ff > CEIL);
   assign flags.above = !live_ff || (segment_ff > cmd.key);

   // pair membership for the odd/even swap pass
   assign pair_left  = (pos.odd == cmd.phase) && !pos.last;
   assign pair_right = (pos.odd != cmd.phase) && !pos.first;

   assign dec_count = (count_ff != '0) ? count_ff - 1'b1 : '0;

   always_comb begin
      next_entry = entry;
      unique case (cmd.op)
         OP_HOLD: begin
         end
         OP_INC: begin
            if (flags.hit && !flags.sat) next_entry.count = count_ff + 1'b1;
         end
         OP_INSERT: begin
            // shift right behind the insertion point, take the key at it
            if (left_above) begin
               next_entry = left_entry;
            end else if (flags.above) begin
               next_entry = '{live: 1'b1, segment: cmd.key, count: COUNT_W'(1)};
            end
         end
         OP_DEC: begin
            if (live_ff) begin
               next_entry.count = dec_count;
               next_entry.live  = (dec_count != '0);
            end
         end
         OP_SWAP: begin
            if (pair_left && !live_ff && right_entry.live) begin
               next_entry = right_entry;
            end else if (pair_right && !left_entry.live && live_ff) begin
               next_entry = left_entry;
            end
         end
         OP_ROTATE: begin
            next_entry = right_entry;
         end
         OP_CLEAR: begin
            next_entry.live  = 1'b0;
            next_entry.count = '0;
         end
         default: begin
         end
      endcase
      live_in    = next_entry.live;
      segment_in = next_entry.segment;
      count_in   = next_entry.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         live_ff  <= live_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      segment_ff <= segment_in;
   end

endmodule

// ===== hw/rtl/mea_hot_segment_tracker.sv =====
// Top level: hot segment tracker, a frequent-items counter chain over memory segments.
//
//   channel   direction  handshake            word
//   req_chan  in         valid/ready          kind, address, is_write, is_store_or_writeback
//   rsp_chan  out        valid/ready          status, entry_valid, segment, count, last
//   csr_*     in         csr_wr_en, no wait   csr_index, csr_data
//
// An access is taken while idle, then looked up across all cells and the chain updated
// once the response register has room. A decrement of a full table is followed by
// odd/even swap passes that pack the surviving entries back to the front of the chain.
// A dump rotates the whole chain once and then passes through a closing state; an empty
// table gives its single blank word, without rotating, before the closing state.
// Reset is synchronous: the table is empty at once, there is no clearing pass.
// A stalled response holds in the output register; the next request is still taken.
module mea_hot_segment_tracker #(
   parameter int ENTRIES       = hst_pkg::DEF_ENTRIES,
   parameter int SEGMENT_SHIFT = hst_pkg::DEF_SEGMENT_SHIFT,
   parameter int COUNT_CEILING = hst_pkg::DEF_COUNT_CEILING
) (
   input  logic                            clock,
   input  logic                            reset,
   hst_req_if.sink                         req_chan,
   hst_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [hst_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hst_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hst_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_COMPACT = 3'd2;
   localparam logic [2:0] S_DUMP    = 3'd3;
   localparam logic [2:0] S_FINISH  = 3'd4;

   // configuration
   logic [CAP_W-1:0] capacity_ff;
   logic             ignore_writes_ff;
   logic             ignore_stores_ff;
   logic             clear_on_dump_ff;

   // held request word
   logic [ADDR_W-1:0] address_ff;
   logic              is_write_ff;
   logic              is_store_ff;

   // sequencer
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] rot_ff, rot_in;
   logic             phase_ff, phase_in;

   // response register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                entry_valid_ff, entry_valid_in;
   logic [SEG_W-1:0]    segment_ff, segment_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                last_ff, last_in;
   logic                emit;
   logic                out_free;

   // chain
   cell_cmd_type   cmd;
   cell_op_type    op;
   logic [SEG_W-1:0] key;
   entry_type      entries [ENTRIES];
   cell_flags_type flags [ENTRIES];
   logic [ENTRIES-1:0] hit_vec;
   logic [ENTRIES-1:0] sat_vec;
   logic [ENTRIES-2:0] hole_vec;
   logic any_hit;
   logic any_sat;
   logic table_full;
   logic unpacked;
   logic filtered;
   logic out_of_range;
   logic req_take;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign key = SEG_W'(address_ff >> SEGMENT_SHIFT);

   assign cmd.op    = op;
   assign cmd.key   = key;
   assign cmd.phase = phase_ff;

   // build the chain: left neighbour feeds inserts, right neighbour feeds rotation
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      cell_pos_type pos;
      entry_type    left_e;
      entry_type    right_e;
      logic         left_ab;

      assign pos = '{first: (i == 0), last: (i == ENTRIES - 1), odd: 1'(i % 2)};

      if (i == 0) begin : g_head
         assign left_e  = DEAD_ENTRY;
         assign left_ab = 1'b0;
      end else begin : g_body
         assign left_e  = entries[i-1];
         assign left_ab = flags[i-1].above;
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign right_e = entries[0];
      end else begin : g_inner
         assign right_e = entries[i+1];
         assign hole_vec[i] = !entries[i].live && entries[i+1].live;
      end

      assign hit_vec[i] = flags[i].hit;
      assign sat_vec[i] = flags[i].sat;

      hst_cell #(
         .COUNT_CEILING(COUNT_CEILING)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .pos         (pos),
         .left_entry  (left_e),
         .right_entry (right_e),
         .left_above  (left_ab),
         .entry       (entries[i]),
         .flags       (flags[i])
      );
   end

   assign any_hit    = |hit_vec;
   assign any_sat    = |sat_vec;
   assign table_full = entries[ENTRIES-1].live;   // live entries stay packed at the front
   assign unpacked   = |hole_vec;

   assign filtered     = (ignore_stores_ff && is_store_ff) || (ignore_writes_ff && is_write_ff);
   assign out_of_range = {1'b0, address_ff} >= capacity_ff;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      rot_in         = rot_ff;
      phase_in       = phase_ff;
      op             = OP_HOLD;
      emit           = 1'b0;
      status_in      = status_ff;
      entry_valid_in = 1'b0;
      segment_in     = '0;
      count_in       = '0;
      last_in        = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               rot_in   = '0;
               state_in = (req_chan.kind == KIND_DUMP) ? S_DUMP : S_EXEC;
            end
         end
         S_EXEC: begin
            // wait for room in the response register, then classify and update
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               priority if (filtered) begin
                  status_in = STAT_FILTERED;
               end else if (out_of_range) begin
                  status_in = STAT_OUT_OF_RANGE;
               end else if (any_hit) begin
                  op        = OP_INC;
                  status_in = any_sat ? STAT_SATURATED : STAT_INCREMENTED;
               end else if (!table_full) begin
                  op        = OP_INSERT;
                  status_in = STAT_INSERTED;
               end else begin
                  op        = OP_DEC;
                  status_in = STAT_DECREMENTED;
                  state_in  = S_COMPACT;
               end
            end
         end
         S_COMPACT: begin
            // close the holes left by freed entries, alternating pair phase
            if (unpacked) begin
               op       = OP_SWAP;
               phase_in = !phase_ff;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DUMP: begin
            status_in = STAT_DUMP;
            if (!entries[0].live && rot_ff == '0) begin
               // empty table: one word with no entry
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_FINISH;
               end
            end else if (!entries[0].live || out_free) begin
               op     = OP_ROTATE;
               rot_in = rot_ff + 1'b1;
               if (entries[0].live) begin
                  emit           = 1'b1;
                  entry_valid_in = 1'b1;
                  segment_in     = entries[0].segment;
                  count_in       = entries[0].count;
                  last_in        = (rot_ff == LAST_IDX) || !entries[1].live;
               end
               if (rot_ff == LAST_IDX) state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (clear_on_dump_ff) op = OP_CLEAR;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rot_ff       <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rot_ff   <= rot_in;
         phase_ff <= phase_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the request word and the response word
   always_ff @(posedge clock) begin
      if (req_take) begin
         address_ff  <= req_chan.address;
         is_write_ff <= req_chan.is_write;
         is_store_ff <= req_chan.is_store_or_writeback;
      end
      if (emit) begin
         status_ff      <= status_in;
         entry_valid_ff <= entry_valid_in;
         segment_ff     <= segment_in;
         count_ff       <= count_in;
         last_ff        <= last_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff      <= CAPACITY_RESET;
         ignore_writes_ff <= 1'b0;
         ignore_stores_ff <= 1'b0;
         clear_on_dump_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CAPACITY:      capacity_ff      <= csr_data[CAP_W-1:0];
            CSR_IGNORE_WRITES: ignore_writes_ff <= csr_data[0];
            CSR_IGNORE_STORES: ignore_stores_ff <= csr_data[0];
            CSR_CLEAR_ON_DUMP: clear_on_dump_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.entry_valid = entry_valid_ff;
   assign rsp_chan.segment     = segment_ff;
   assign rsp_chan.count       = count_ff;
   assign rsp_chan.last        = last_ff;

endmodule

// ===== bench/tb_mea_hot_segment_tracker.sv =====
// Testbench: random and directed check of the hot segment tracker against a local table predictor.
module tb_mea_hot_segment_tracker;
   import hst_pkg::*;

   localparam int          PERIOD        = 10;
   localparam int          RESET_CYCLES  = 10;
   localparam int          ENTRIES       = DEF_ENTRIES;
   localparam int          SEGMENT_SHIFT = DEF_SEGMENT_SHIFT;
   localparam int          COUNT_TOP     = DEF_COUNT_CEILING + 1;
   // A full-table decrement repacks the chain and a dump rotates it: allow both.
   localparam int          SETTLE_CYCLES = 2 * ENTRIES + 20;
   localparam int          LONG_HOLD     = 600;
   localparam int unsigned CYCLE_LIMIT   = 3000000;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] address;
      logic              is_write;
      logic              is_store;
   } access_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                entry_valid;
      logic [SEG_W-1:0]    segment;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } rsp_word_type;

   // Clock, reset and the configuration port; every input is known from time zero.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_CAPACITY;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   logic            send_valid = 1'b0;
   access_word_type send_word  = '0;
   logic            take_ready = 1'b0;

   hst_req_if req_bus ();
   hst_rsp_if rsp_bus ();

   assign req_bus.valid                 = send_valid;
   assign req_bus.kind                  = send_word.kind;
   assign req_bus.address               = send_word.address;
   assign req_bus.is_write              = send_word.is_write;
   assign req_bus.is_store_or_writeback = send_word.is_store;
   assign rsp_bus.ready                 = take_ready;

   mea_hot_segment_tracker #(
      .ENTRIES       (DEF_ENTRIES),
      .SEGMENT_SHIFT (DEF_SEGMENT_SHIFT),
      .COUNT_CEILING (DEF_COUNT_CEILING)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Predictor state: shadow registers and our own copy of the counter table.
   // ---------------------------------------------------------------------------------------
   logic [CAP_W-1:0]   cap_limit    = CAPACITY_RESET;
   logic               skip_writes  = 1'b0;
   logic               skip_stores  = 1'b0;
   logic               wipe_on_dump = 1'b0;
   logic [SEG_W-1:0]   seg_of  [ENTRIES];
   logic [COUNT_W-1:0] cnt_of  [ENTRIES];
   logic               live_of [ENTRIES];

   access_word_type pending[$];      // words waiting for the driver
   rsp_word_type    owed_results[$]; // results the block still owes, oldest first

   int          errors        = 0;
   int          words_taken   = 0;
   int          results_seen  = 0;
   int          status_tally [8];
   int unsigned cycle_count   = 0;

   // Idling knobs, set by the stimulus between phases.
   int   send_gap_pct    = 0;
   int   take_stall_pct  = 0;
   int   gap_left        = 0;
   int   stall_left      = 0;
   int   hold_left       = 0;
   logic long_hold_due   = 1'b0;
   logic long_hold_taken = 1'b0;

   function automatic void wipe_table();
      for (int i = 0; i < ENTRIES; i++) begin
         seg_of[i]  = '0;
         cnt_of[i]  = '0;
         live_of[i] = 1'b0;
      end
   endfunction

   // Count one access against the table: hit, insert into the lowest free slot,
   // or, with the table full, age every entry by one and free those at zero.
   function automatic logic [STATUS_W-1:0] count_segment(logic [SEG_W-1:0] seg);
      int free_slot;
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (live_of[i] && seg_of[i] == seg) begin
            if (cnt_of[i] < COUNT_W'(COUNT_TOP)) begin
               cnt_of[i] = cnt_of[i] + 1'b1;
               return STAT_INCREMENTED;
            end
            return STAT_SATURATED;
         end
      end
      for (int i = 0; i < ENTRIES; i++)
         if (!live_of[i] && free_slot < 0)
            free_slot = i;
      if (free_slot >= 0) begin
         live_of[free_slot] = 1'b1;
         seg_of[free_slot]  = seg;
         cnt_of[free_slot]  = COUNT_W'(1);
         return STAT_INSERTED;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (live_of[i]) begin
            if (cnt_of[i] != '0)
               cnt_of[i] = cnt_of[i] - 1'b1;
            if (cnt_of[i] == '0)
               live_of[i] = 1'b0;
         end
      end
      return STAT_DECREMENTED;
   endfunction

   // Owe one word per live entry in ascending segment order; an empty table owes one
   // blank word. Segments of live entries are unique, so a strict "above previous" walk works.
   function automatic void dump_table();
      rsp_word_type     r;
      logic [SEG_W-1:0] prev;
      logic             have_prev;
      int               best;
      int               n;
      int               live_total;
      have_prev  = 1'b0;
      prev       = '0;
      n          = 0;
      live_total = 0;
      for (int i = 0; i < ENTRIES; i++)
         if (live_of[i])
            live_total++;
      for (int k = 0; k < live_total; k++) begin
         best = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (live_of[i] && (!have_prev || seg_of[i] > prev) &&
                (best < 0 || seg_of[i] < seg_of[best]))
               best = i;
         n++;
         r = '{STAT_DUMP, 1'b1, seg_of[best], cnt_of[best], (n == live_total)};
         owed_results.insert(owed_results.size(), r);
         prev      = seg_of[best];
         have_prev = 1'b1;
      end
      if (live_total == 0) begin
         r = '{STAT_DUMP, 1'b0, '0, '0, 1'b1};
         owed_results.insert(owed_results.size(), r);
         n = 1;
      end
      status_tally[STAT_DUMP] += n;
      if (wipe_on_dump)
         wipe_table();
   endfunction

   // Work out what one accepted word makes the block return.
   function automatic void tally_request(access_word_type w);
      rsp_word_type     r;
      logic [SEG_W-1:0] seg;
      seg = SEG_W'(w.address >> SEGMENT_SHIFT);
      if (w.kind == KIND_DUMP) begin
         dump_table();
      end else begin
         r      = '0;
         r.last = 1'b1;
         // Filters win over the range check.
         if ((skip_stores && w.is_store) || (skip_writes && w.is_write))
            r.status = STAT_FILTERED;
         else if (CAP_W'(w.address) >= cap_limit)
            r.status = STAT_OUT_OF_RANGE;
         else
            r.status = count_segment(seg);
         status_tally[r.status]++;
         owed_results.insert(owed_results.size(), r);
      end
   endfunction

   function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver: offer pending words, predict each one at the edge that accepts it.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : feed
      logic            fire;
      logic            nxt_valid;
      access_word_type nxt_word;
      fire      = send_valid && req_bus.ready;
      nxt_valid = send_valid && !fire;
      nxt_word  = send_word;
      if (reset) begin
         nxt_valid = 1'b0;
      end else begin
         if (fire) begin
            tally_request(send_word);
            words_taken++;
         end
         // Hold a word on offer until taken; between words, idle in random bursts.
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
               gap_left = $urandom_range(0, 12);
            end else if (pending.size() != 0) begin
               nxt_word  = pending[0];
               pending.delete(0);
               nxt_valid = 1'b1;
            end
         end
      end
      send_valid <= nxt_valid;
      send_word  <= nxt_word;
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: take result words, compare against the oldest owed word, stall at random.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : collect
      rsp_word_type got;
      rsp_word_type want;
      logic         nxt_ready;
      nxt_ready = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && take_ready) begin
            got.status      = rsp_bus.status;
            got.entry_valid = rsp_bus.entry_valid;
            got.segment     = rsp_bus.segment;
            got.count       = rsp_bus.count;
            got.last        = rsp_bus.last;
            results_seen++;
            if (owed_results.size() == 0) begin
               errors++;
               $display("%0t: result word with nothing owed, expected none, actual %0h",
                        $time, got);
            end else begin
               want = owed_results[0];
               owed_results.delete(0);
               report_field("status", 32'(want.status), 32'(got.status));
               report_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
               report_field("segment", 32'(want.segment), 32'(got.segment));
               report_field("count", 32'(want.count), 32'(got.count));
               report_field("last", 32'(want.last), 32'(got.last));
            end
         end
         // Start the long hold-off once, when asked; count it down here.
         if (long_hold_due && !long_hold_taken) begin
            hold_left       = LONG_HOLD;
            long_hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (take_stall_pct > 0 && $urandom_range(99) < take_stall_pct) begin
            stall_left = $urandom_range(0, 12);
         end else begin
            nxt_ready = 1'b1;
         end
      end
      take_ready <= nxt_ready;
   end

   // Watchdog: end the run if it overstays.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run timed out after %0d cycles", $time, cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------------
   task automatic queue_access(logic [ADDR_W-1:0] addr, logic wr, logic st);
      pending.insert(pending.size(), '{KIND_ACCESS, addr, wr, st});
   endtask

   // Address and marks of a dump are don't-care: fill them with noise.
   task automatic queue_dump();
      pending.insert(pending.size(), '{KIND_DUMP, ADDR_W'({$urandom(), $urandom()}),
                                       1'($urandom()), 1'($urandom())});
   endtask

   function automatic logic [ADDR_W-1:0] addr_in(logic [SEG_W-1:0] seg);
      return (ADDR_W'(seg) << SEGMENT_SHIFT) |
             ADDR_W'($urandom_range(0, (1 << SEGMENT_SHIFT) - 1));
   endfunction

   function automatic logic [ADDR_W-1:0] any_addr();
      return ADDR_W'({$urandom(), $urandom()});
   endfunction

   function automatic logic chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Wait until every word is sent and every owed result is back, then let the
   // block finish any repack or rotation that trails its last result.
   task automatic wait_quiet();
      while (pending.size() != 0 || send_valid || owed_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_CAPACITY:      cap_limit    = CAP_W'(val);
         CSR_IGNORE_WRITES: skip_writes  = val[0];
         CSR_IGNORE_STORES: skip_stores  = val[0];
         CSR_CLEAR_ON_DUMP: wipe_on_dump = val[0];
         default: ;
      endcase
   endtask

   // Write all four registers; the block must be idle.
   task automatic configure(logic [CAP_W-1:0] cap, logic wr, logic st, logic clr);
      write_csr(CSR_CAPACITY, CSR_DATA_W'(cap));
      write_csr(CSR_IGNORE_WRITES, CSR_DATA_W'(wr));
      write_csr(CSR_IGNORE_STORES, CSR_DATA_W'(st));
      write_csr(CSR_CLEAR_ON_DUMP, CSR_DATA_W'(clr));
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      logic [SEG_W-1:0] hot_seg;
      logic [SEG_W-1:0] edge_seg;
      logic [SEG_W-1:0] seg_pool [$];
      logic [CAP_W-1:0] cap;

      wipe_table();
      for (int i = 0; i < 8; i++)
         status_tally[i] = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, reset settings: empty dump, extreme addresses, sorted dump.
      send_gap_pct   = 20;
      take_stall_pct = 20;
      queue_dump();
      queue_access({ADDR_W{1'b1}}, 1'b1, 1'b1);          // top segment, slot 0
      queue_access('0, 1'b0, 1'b0);                       // segment 0, slot 1
      queue_access(ADDR_W'(12'h7FF), 1'b1, 1'b0);         // same segment again
      queue_access(ADDR_W'(12'h800), 1'b0, 1'b1);         // segment 1
      queue_dump();                                       // must come out sorted
      wait_quiet();

      // Directed, both filters on, half-range capacity, clear after dump.
      cap = CAP_W'(1) << (ADDR_W - 1);
      configure(cap, 1'b1, 1'b1, 1'b1);
      queue_access('0, 1'b1, 1'b0);
      queue_access('0, 1'b0, 1'b1);
      queue_access({ADDR_W{1'b1}}, 1'b1, 1'b1);          // filtered before range check
      queue_access(ADDR_W'(cap), 1'b0, 1'b0);            // first address out of range
      queue_access(ADDR_W'(cap - 1'b1), 1'b0, 1'b0);     // last address in range
      queue_access(ADDR_W'(12'h7FF), 1'b0, 1'b0);
      queue_dump();
      queue_dump();                                      // table cleared by the first
      wait_quiet();

      // Hot segment: full capacity, one segment hammered so its count climbs high.
      configure({CAP_W{1'b1}}, 1'b0, 1'b0, 1'b0);
      send_gap_pct   = 0;
      take_stall_pct = 30;
      hot_seg = SEG_W'($urandom());
      for (int i = 0; i < 100; i++) begin
         if (chance(3))
            queue_dump();
         else if (chance(96))
            queue_access(addr_in(hot_seg), 1'($urandom()), 1'($urandom()));
         else
            queue_access(any_addr(), 1'($urandom()), 1'($urandom()));
      end
      queue_dump();
      wait_quiet();

      // Churn: random capacity, write filter, a pool wide enough to fill the table
      // and force aging. The sink holds off once for a long stretch to back the block up.
      edge_seg = SEG_W'($urandom_range(200, (1 << SEG_W) - 1));
      cap = (CAP_W'(edge_seg) << SEGMENT_SHIFT) |
            CAP_W'($urandom_range(0, (1 << SEGMENT_SHIFT) - 1));
      configure(cap, 1'b1, 1'b0, 1'b0);
      send_gap_pct   = 25;
      take_stall_pct = 25;
      seg_pool.delete();
      for (int i = 0; i < 110; i++)
         seg_pool.insert(seg_pool.size(),
                         i < 4 ? edge_seg : SEG_W'($urandom_range(0, edge_seg - 1)));
      for (int i = 0; i < 120; i++) begin
         if (chance(4))
            queue_dump();
         else if (chance(6))
            queue_access(any_addr(), 1'($urandom()), 1'($urandom()));
         else
            queue_access(addr_in(seg_pool[$urandom_range(0, seg_pool.size() - 1)]),
                         chance(20), chance(30));
      end
      queue_dump();
      long_hold_due = 1'b1;
      wait_quiet();

      // Zero capacity: every counted access is out of range; store filter still wins.
      configure('0, 1'b0, 1'b1, 1'b0);
      send_gap_pct   = 40;
      take_stall_pct = 10;
      for (int i = 0; i < 16; i++)
         queue_access(any_addr(), 1'($urandom()), 1'($urandom()));
      queue_dump();
      wait_quiet();

      // Final stretch, no idling: a fresh pool, first in order, then mixed.
      configure(CAPACITY_RESET, 1'b0, 1'b1, 1'b1);
      send_gap_pct   = 0;
      take_stall_pct = 0;
      seg_pool.delete();
      for (int i = 0; i < 70; i++)
         seg_pool.insert(seg_pool.size(), SEG_W'($urandom()));
      for (int i = 0; i < 30; i++)
         queue_access(addr_in(seg_pool[i]), 1'($urandom()), 1'b0);
      for (int i = 0; i < 25; i++) begin
         if (chance(5))
            queue_dump();
         else
            queue_access(addr_in(seg_pool[$urandom_range(0, 69)]),
                         1'($urandom()), chance(15));
      end
      queue_dump();
      wait_quiet();

      $display("Covered %0d request words and %0d result words over six register settings.",
               words_taken, results_seen);
      $display("Access outcomes: inc %0d, sat %0d, ins %0d, aged %0d, filt %0d, range %0d;%s%0d",
               status_tally[STAT_INCREMENTED], status_tally[STAT_SATURATED],
               status_tally[STAT_INSERTED], status_tally[STAT_DECREMENTED],
               status_tally[STAT_FILTERED], status_tally[STAT_OUT_OF_RANGE],
               " dump words ", status_tally[STAT_DUMP]);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
